/* rtl/iis_pkg.sv */
// ----------------------------------------------------------------------------
// iis_pkg
// Shared constants for the streaming integral image block: result width,
// configuration register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package iis_pkg;

  // Width of a summed-area result; results wrap modulo 2^SUM_W.
  localparam int unsigned SUM_W      = 28;
  // Width of a configuration register and of the configuration data port.
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Frame size after reset, before clamping to the maximum.
  localparam int unsigned SIZE_RESET = 1024;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned PIXEL_BITS_DEF = 8;

endpackage

/* rtl/integral_image_stream.sv */
// ----------------------------------------------------------------------------
// integral_image_stream
// Streaming summed-area table: each pixel in raster order yields the sum of
// all pixels above and to the left of it, itself included.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o    | pixel_i
//  out     | output    | out_valid_o / out_ready_i  | area_sum_o, row_end_o,
//          |           |                            | frame_end_o
//  cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
//  One pixel is accepted per cycle while the output is not stalled; its result
//  passes the middle stage and the output register before it can be taken.
//  The line store is read when a pixel is accepted and written back when the
//  item leaves the middle stage, so the single RAM read and write port pair
//  sets the one-item-a-cycle rate. With one-pixel rows the value written in a
//  cycle is forwarded to the pixel read in that same cycle. A stalled output
//  holds the middle stage and then the input; no clearing pass is needed after
//  reset.
//
module integral_image_stream
  import iis_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SUM_W-1:0]      area_sum_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned RUN_W = PIXEL_BITS + COL_W;
  localparam logic [CFG_W-1:0] WIDTH_RST =
    CFG_W'((SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET);
  localparam logic [CFG_W-1:0] HEIGHT_RST =
    CFG_W'((SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET);

  // Configuration
  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic             restart;

  // Frame position and running row sum
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [RUN_W-1:0] run_sum;
  logic             last_col, last_row;

  // Middle stage, waiting for the line store read data
  logic             s1_valid_q, s1_valid_d;
  logic [COL_W-1:0] s1_col_q;
  logic [SUM_W-1:0] s1_run_q;
  logic             s1_top_q;
  logic             s1_row_end_q;
  logic             s1_frame_end_q;
  logic             fwd_hit_q;
  logic [SUM_W-1:0] fwd_data_q;
  logic             s1_fire;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] area_q;
  logic             row_end_q;
  logic             frame_end_q;

  logic             in_accept;
  logic [SUM_W-1:0] ram_rdata;
  logic [SUM_W-1:0] above;
  logic [SUM_W-1:0] area;

  // ---------------------------------------------------------------------------
  // Configuration: zero acts as one, oversize acts as the maximum.
  // ---------------------------------------------------------------------------
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          restart = 1'b1;
          if (cfg_data_i == '0) begin
            width_d = CFG_W'(1);
          end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
            width_d = CFG_W'(MAX_WIDTH);
          end else begin
            width_d = cfg_data_i;
          end
        end
        REG_FRAME_HEIGHT: begin
          restart = 1'b1;
          if (cfg_data_i == '0) begin
            height_d = CFG_W'(1);
          end else if (32'(cfg_data_i) > 32'(MAX_HEIGHT)) begin
            height_d = CFG_W'(MAX_HEIGHT);
          end else begin
            height_d = cfg_data_i;
          end
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: advance the position and issue the line store read.
  // ---------------------------------------------------------------------------
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_accept  = in_valid_i && in_ready_o;

  assign run_sum  = run_q + RUN_W'(pixel_i);
  assign last_col = (32'(col_q) + 32'd1) >= 32'(width_q);
  assign last_row = (32'(row_q) + 32'd1) >= 32'(height_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    run_d = run_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
      run_d = '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_d = '0;
        run_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
        run_d = run_sum;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Middle stage: add the value above and write it back.
  // ---------------------------------------------------------------------------
  assign above = s1_top_q ? '0 : (fwd_hit_q ? fwd_data_q : ram_rdata);
  assign area  = s1_run_q + above;

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_fire);
  assign out_valid_d = s1_fire || (out_valid_q && !out_ready_i);

  iis_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (area),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      col_q       <= '0;
      row_q       <= '0;
      run_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      run_q       <= run_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q       <= col_q;
      s1_run_q       <= SUM_W'(run_sum);
      s1_top_q       <= (row_q == '0);
      s1_row_end_q   <= last_col;
      s1_frame_end_q <= last_col && last_row;
      // The item ahead writes this column in the cycle of the read.
      fwd_hit_q      <= s1_fire && (s1_col_q == col_q);
      fwd_data_q     <= area;
    end
    if (s1_fire) begin
      area_q      <= area;
      row_end_q   <= s1_row_end_q;
      frame_end_q <= s1_frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign area_sum_o  = area_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_frame_end_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end flagged on an item that does not end its row");

  a_col_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last_col && !restart |=> col_q == '0)
    else $error("column did not return to zero after the last column");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

  a_fwd_only_narrow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && s1_fire && (s1_col_q == col_q) |-> width_q == CFG_W'(1))
    else $error("same column in flight twice with a row wider than one");

endmodule

/* rtl/iis_ram.sv */
// ----------------------------------------------------------------------------
// iis_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module iis_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
